>>> src/merge_sort_engine_assert.svh
// ----------------------------------------------------------------------------
// merge_sort_engine_assert.svh
// Assertion macros used by the merge sort engine checker.
// ----------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_ASSERT_SVH
`define MERGE_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MSE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mse: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mse: next-cycle check failed");

`endif

>>> src/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Types and constants of the merge sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int AW        = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W     = CNT_W + 1;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_set;
    logic                     overflow;
  } out_t;

  // Memory request from the sequencer: one write, two reads on both banks.
  typedef struct packed {
    logic [1:0]        we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr_a;
    logic [AW-1:0]     raddr_b;
    logic              rd_bank;
  } mem_req_t;

  // Output register control.
  typedef struct packed {
    logic load;
    logic last;
    logic ovf;
  } out_ev_t;

endpackage

`default_nettype wire

>>> src/merge_sort_engine.sv
// ----------------------------------------------------------------------------
// merge_sort_engine
// Collects a set of signed words, merge sorts them, streams them out.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o / in_i) takes one word a beat, one
// beat a cycle while loading. The beat with is_last set closes the set. Up to
// MAX_ITEMS words are kept; later words are dropped and every output beat of
// that set then shows overflow.
// The sort runs bottom-up merge passes between two banks of RAM: each pass
// writes every word once, after a priming state (ST_PRIME) per pair of runs
// for the RAM read latency. The output channel (out_valid_o / out_ready_i /
// out_o) then gives the sorted words: each is read (ST_ORD), loaded into the
// output register (ST_OCAP) and held until the sink takes it (ST_OWAIT)
// before the next is read; end_of_set marks the final one. A lone word skips
// the sort. Input is held off during the sort and the read-out.
// When the sink stalls, hold the output beat and let the read-out wait. Reset
// empties the set and returns to loading; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sort_engine
  import mse_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  mem_req_t          mem_req;
  out_ev_t           oev;
  logic [DATA_W-1:0] b0_a, b0_b, b1_a, b1_b;
  logic [DATA_W-1:0] rd_a, rd_b;
  logic              out_valid_q;
  out_t              out_q;
  logic              out_fire;

  // Bank 0 holds the loaded set; merges ping-pong between the two banks.
  mse_ram #(.Depth(MAX_ITEMS), .Width(DATA_W)) u_bank0 (
    .clk_i     (clk_i),
    .we_i      (mem_req.we[0]),
    .waddr_i   (mem_req.waddr),
    .wdata_i   (mem_req.wdata),
    .raddr_a_i (mem_req.raddr_a),
    .raddr_b_i (mem_req.raddr_b),
    .rdata_a_o (b0_a),
    .rdata_b_o (b0_b)
  );

  mse_ram #(.Depth(MAX_ITEMS), .Width(DATA_W)) u_bank1 (
    .clk_i     (clk_i),
    .we_i      (mem_req.we[1]),
    .waddr_i   (mem_req.waddr),
    .wdata_i   (mem_req.wdata),
    .raddr_a_i (mem_req.raddr_a),
    .raddr_b_i (mem_req.raddr_b),
    .rdata_a_o (b1_a),
    .rdata_b_o (b1_b)
  );

  // Pick the bank being read; the select holds across the read latency.
  assign rd_a = mem_req.rd_bank ? b1_a : b0_a;
  assign rd_b = mem_req.rd_bank ? b1_b : b0_b;

  mse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .rd_a_i     (rd_a),
    .rd_b_i     (rd_b),
    .out_fire_i (out_fire),
    .mem_o      (mem_req),
    .oev_o      (oev)
  );

  assign out_fire = out_valid_q && out_ready_i;

  // Output register: load a beat from the read port, drop it on accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (oev.load) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oev.load) begin
      out_q.sorted_value <= rd_a;
      out_q.end_of_set   <= oev.last;
      out_q.overflow     <= oev.ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

>>> src/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_ram #(
  parameter int Depth = 64,
  parameter int Width = 32,
  localparam int Aw   = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_a_i,
  input  wire logic [Aw-1:0]    raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> src/mse_ctrl.sv
// ----------------------------------------------------------------------------
// mse_ctrl
// Sequencer: load, bottom-up merge passes between two banks, read-out.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_ctrl
  import mse_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_t               in_i,
  input  wire logic [DATA_W-1:0] rd_a_i,
  input  wire logic [DATA_W-1:0] rd_b_i,
  input  wire logic              out_fire_i,
  output mem_req_t               mem_o,
  output out_ev_t                oev_o
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_PRIME = 3'd1;
  localparam logic [2:0] ST_MERGE = 3'd2;
  localparam logic [2:0] ST_ORD   = 3'd3;
  localparam logic [2:0] ST_OCAP  = 3'd4;
  localparam logic [2:0] ST_OWAIT = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, n_q, n_d, w_q, w_d, lo_q, lo_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d, mid_q, mid_d, hi_q, hi_d;
  logic [CNT_W-1:0] r_q, r_d;
  logic             drop_q, drop_d, src_q, src_d, res_q, res_d;

  logic             run_set;
  logic [CNT_W-1:0] run_lo, run_w, n_new, k_inc, r_inc;
  logic [SUM_W-1:0] mid_sum, hi_sum, lo_nx, w_nx;
  logic             take_left, room;

  assign room  = cnt_q < CNT_W'(MAX_ITEMS);
  assign k_inc = k_q + CNT_W'(1);
  assign r_inc = r_q + CNT_W'(1);
  assign lo_nx = SUM_W'(lo_q) + (SUM_W'(w_q) << 1);
  assign w_nx  = SUM_W'(w_q) << 1;
  assign n_new = room ? cnt_q + CNT_W'(1) : cnt_q;

  // Left run wins ties, which keeps the sort stable.
  assign take_left = (i_q < mid_q) &&
                     ((j_q >= hi_q) || ($signed(rd_a_i) <= $signed(rd_b_i)));

  assign mid_sum = SUM_W'(run_lo) + SUM_W'(run_w);
  assign hi_sum  = SUM_W'(run_lo) + (SUM_W'(run_w) << 1);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    n_d        = n_q;
    w_d        = w_q;
    lo_d       = lo_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    mid_d      = mid_q;
    hi_d       = hi_q;
    r_d        = r_q;
    drop_d     = drop_q;
    src_d      = src_q;
    res_d      = res_q;
    run_set    = 1'b0;
    run_lo     = lo_q;
    run_w      = w_q;
    in_ready_o = 1'b0;
    mem_o      = '0;
    oev_o      = '0;

    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (room) begin
            mem_o.we[0] = 1'b1;
            mem_o.waddr = cnt_q[AW-1:0];
            mem_o.wdata = in_i.value;
            cnt_d       = cnt_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (in_i.is_last) begin
            n_d = n_new;
            r_d = '0;
            if (n_new <= CNT_W'(1)) begin
              res_d   = 1'b0;
              state_d = ST_ORD;
            end else begin
              w_d     = CNT_W'(1);
              src_d   = 1'b0;
              run_lo  = '0;
              run_w   = CNT_W'(1);
              run_set = 1'b1;
              state_d = ST_PRIME;
            end
          end
        end
      end
      ST_PRIME: begin
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        mem_o.we[~src_q] = 1'b1;
        mem_o.waddr      = k_q[AW-1:0];
        mem_o.wdata      = take_left ? rd_a_i : rd_b_i;
        k_d              = k_inc;
        if (take_left) begin
          i_d = i_q + CNT_W'(1);
        end else begin
          j_d = j_q + CNT_W'(1);
        end
        if (k_inc == hi_q) begin
          if (lo_nx >= SUM_W'(n_q)) begin
            // Pass done: flip banks, or finish once one run covers the set.
            if (w_nx >= SUM_W'(n_q)) begin
              res_d   = ~src_q;
              state_d = ST_ORD;
            end else begin
              src_d   = ~src_q;
              w_d     = w_nx[CNT_W-1:0];
              run_lo  = '0;
              run_w   = w_nx[CNT_W-1:0];
              run_set = 1'b1;
              state_d = ST_PRIME;
            end
          end else begin
            run_lo  = lo_nx[CNT_W-1:0];
            run_set = 1'b1;
            state_d = ST_PRIME;
          end
        end
      end
      ST_ORD: begin
        state_d = ST_OCAP;
      end
      ST_OCAP: begin
        oev_o.load = 1'b1;
        oev_o.last = (r_inc == n_q);
        oev_o.ovf  = drop_q;
        state_d    = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (out_fire_i) begin
          if (r_inc == n_q) begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            state_d = ST_LOAD;
          end else begin
            r_d     = r_inc;
            state_d = ST_ORD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // Set up the bounds of the next pair of runs.
    if (run_set) begin
      lo_d  = run_lo;
      i_d   = run_lo;
      k_d   = run_lo;
      mid_d = (mid_sum > SUM_W'(n_d)) ? n_d : mid_sum[CNT_W-1:0];
      hi_d  = (hi_sum > SUM_W'(n_d)) ? n_d : hi_sum[CNT_W-1:0];
      j_d   = mid_d;
    end

    // Reads: the merge heads of the next cycle, or the read-out pointer.
    if (state_q == ST_ORD || state_q == ST_OCAP || state_q == ST_OWAIT) begin
      mem_o.rd_bank = res_q;
      mem_o.raddr_a = r_q[AW-1:0];
    end else begin
      mem_o.rd_bank = src_q;
      mem_o.raddr_a = i_d[AW-1:0];
      mem_o.raddr_b = j_d[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      n_q     <= '0;
      w_q     <= '0;
      lo_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      r_q     <= '0;
      drop_q  <= 1'b0;
      src_q   <= 1'b0;
      res_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      w_q     <= w_d;
      lo_q    <= lo_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      r_q     <= r_d;
      drop_q  <= drop_d;
      src_q   <= src_d;
      res_q   <= res_d;
    end
  end

endmodule

`default_nettype wire

>>> src/mse_checker.sv
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks of the merge sort engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "merge_sort_engine_assert.svh"

module mse_checker
  import mse_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire in_t  in_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_o
);

  // A stalled output beat holds.
  `MSE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_o))

  // Loading and read-out never overlap.
  `MSE_ASSERT_IMPL(a_no_overlap, in_ready_o, !out_valid_o)

  // Closing a set stops the input until its results are out.
  `MSE_ASSERT_NEXT(a_close_set, in_valid_i && in_ready_o && in_i.is_last, !in_ready_o)

  // The final beat of a set hands straight back to loading.
  `MSE_ASSERT_NEXT(a_reopen, out_valid_o && out_ready_i && out_o.end_of_set, in_ready_o)

endmodule

bind merge_sort_engine mse_checker u_mse_checker (.*);

`default_nettype wire
